// ===== hdl/clns_pkg.sv =====
// shared types, constants and tables of the character display nibble sequencer
package clns_pkg;

  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_CMD    = 2'd1,
    REQ_DATA   = 2'd2,
    REQ_CURSOR = 2'd3
  } req_kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } clns_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } clns_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;
    logic last;
    logic out_free;
  } clns_status_t;

  localparam int unsigned IdxW = 4;

  localparam logic [IdxW-1:0] INIT_LAST_IDX  = 4'd13;
  localparam logic [IdxW-1:0] INIT_CLEAR_IDX = 4'd9;
  localparam logic [IdxW-1:0] BYTE_LAST_IDX  = 4'd1;

  localparam logic [7:0] CURSOR_CMD  = 8'h80;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_HOME    = 8'h02;

  localparam logic [10:0] LEAD_POWER_UP  = 11'd2000;
  localparam logic [10:0] LEAD_NONE      = 11'd0;
  localparam logic [12:0] SETTLE_BASE    = 13'd52;
  localparam logic [12:0] SETTLE_FIRST   = 13'd5052;
  localparam logic [12:0] SETTLE_WAKE    = 13'd252;
  localparam logic [12:0] SETTLE_4BIT    = 13'd152;
  localparam logic [12:0] SETTLE_SLOW    = 13'd2052;

  localparam logic [3:0] NIB_WAKE = 4'h3;
  localparam logic [3:0] NIB_4BIT = 4'h2;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  // power-up command list, one entry per command byte
  function automatic logic [7:0] init_cmd(input logic [2:0] n);
    logic [7:0] c;
    case (n)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h08;
      3'd2:    c = 8'h01;
      3'd3:    c = 8'h06;
      default: c = 8'h0C;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/clns_if.sv =====
// valid/ready channels for requests and display strobes
interface clns_req_if;
  import clns_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] value;
  logic [2:0] row;
  logic [5:0] col;

  modport source (output valid, req_type, value, row, col, input ready);
  modport sink   (input valid, req_type, value, row, col, output ready);
endinterface

interface clns_strobe_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [10:0] lead_wait_us;
  logic [12:0] settle_wait_us;
  logic        last;

  modport source (output valid, reg_select, nibble, lead_wait_us, settle_wait_us, last,
                  input ready);
  modport sink   (input valid, reg_select, nibble, lead_wait_us, settle_wait_us, last,
                  output ready);
endinterface

// ===== hdl/char_lcd_nibble_sequencer.sv =====
// top level of the character display nibble sequencer
//
// req_i takes one request per beat: initialise, command byte, data byte or
// set cursor. strobe_o gives one beat per enable strobe of a 4-bit display
// bus: register select, nibble D4..D7, wait before and after the enable
// pulse, and a last flag on the final strobe of the request.
// initialise gives 14 strobes, the other kinds 2, a set cursor with row or
// column out of range gives none and is simply swallowed.
// order: a request's beat is taken into the request register and the
// controller state, and its first strobe then shows from the output register.
// strobes follow one per cycle while the receiver keeps up, as the index
// counter in the datapath walks the strobe list.
// req_i.ready is high only between requests, so one request is worked on at
// a time; the next one is taken while the final strobe still sits in the
// output register.
// a stall on strobe_o holds the output register and freezes the counter.
// reset empties the output register and returns to waiting for a request.
module char_lcd_nibble_sequencer
  import clns_pkg::*;
#(
  parameter int unsigned COLUMNS = 20,
  parameter int unsigned ROWS    = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  clns_req_if.sink      req_i,
  clns_strobe_if.source strobe_o
);

  clns_cmd_t    cmd;
  clns_status_t status;
  logic         req_ready;

  // sequencing control
  clns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .status_i    (status),
    .req_ready_o (req_ready),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // request capture, strobe decode and output register
  clns_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .req      (req_i),
    .strobe   (strobe_o)
  );

endmodule

// ===== hdl/clns_ctrl.sv =====
// sequencing state machine: takes a request, then steps through its strobes
module clns_ctrl
  import clns_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  input  clns_status_t status_i,
  output logic         req_ready_o,
  output clns_cmd_t    cmd_o
);

  clns_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i && !status_i.drop) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.out_free && status_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_RUN: begin
        cmd_o.emit = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/clns_dp.sv =====
// request register, strobe index, strobe field decode and output register
module clns_dp
  import clns_pkg::*;
#(
  parameter int unsigned COLUMNS = 20,
  parameter int unsigned ROWS    = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  clns_cmd_t     cmd_i,
  output clns_status_t  status_o,
  clns_req_if.sink      req,
  clns_strobe_if.source strobe
);

  req_kind_e        kind_q;
  logic [7:0]       byte_q;
  logic [IdxW-1:0]  idx_q;
  logic             out_valid_q;
  logic             rs_q;
  logic [3:0]       nib_q;
  logic [10:0]      lead_q;
  logic [12:0]      settle_q;
  logic             last_q;

  req_kind_e        req_kind;
  logic [7:0]       cursor_addr;
  logic [7:0]       load_byte;
  logic             cursor_bad;
  logic [IdxW-1:0]  cmd_pos;
  logic [7:0]       cur_byte;
  logic             s_rs;
  logic [3:0]       s_nib;
  logic [10:0]      s_lead;
  logic [12:0]      s_settle;
  logic             s_last;

  assign req_kind    = req_kind_e'(req.req_type);
  assign cursor_addr = CURSOR_CMD | (row_base(req.row[1:0]) + {2'b00, req.col});
  assign cursor_bad  = (req.row >= 3'(ROWS)) || ({1'b0, req.col} >= 7'(COLUMNS));
  assign load_byte   = (req_kind == REQ_CURSOR) ? cursor_addr : req.value;

  // init strobes 4..13 carry the power-up command list, two per byte
  assign cmd_pos  = idx_q - 4'd4;
  assign cur_byte = (kind_q == REQ_INIT) ? init_cmd(cmd_pos[3:1]) : byte_q;

  always_comb begin
    s_rs     = (kind_q == REQ_DATA);
    s_nib    = idx_q[0] ? cur_byte[3:0] : cur_byte[7:4];
    s_lead   = LEAD_NONE;
    s_settle = SETTLE_BASE;
    s_last   = (idx_q == BYTE_LAST_IDX);
    if (kind_q == REQ_INIT) begin
      s_last = (idx_q == INIT_LAST_IDX);
      case (idx_q)
        4'd0: begin
          s_nib    = NIB_WAKE;
          s_lead   = LEAD_POWER_UP;
          s_settle = SETTLE_FIRST;
        end
        4'd1, 4'd2: begin
          s_nib    = NIB_WAKE;
          s_settle = SETTLE_WAKE;
        end
        4'd3: begin
          s_nib    = NIB_4BIT;
          s_settle = SETTLE_4BIT;
        end
        INIT_CLEAR_IDX, INIT_LAST_IDX: s_settle = SETTLE_SLOW;
        default: ;
      endcase
    end else if (kind_q != REQ_DATA && idx_q == BYTE_LAST_IDX &&
                 (byte_q == CMD_CLEAR || byte_q == CMD_HOME)) begin
      s_settle = SETTLE_SLOW;
    end
  end

  // request and index registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= req_kind;
      byte_q <= load_byte;
      idx_q  <= '0;
    end else if (cmd_i.emit) begin
      idx_q  <= idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (strobe.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rs_q     <= s_rs;
      nib_q    <= s_nib;
      lead_q   <= s_lead;
      settle_q <= s_settle;
      last_q   <= s_last;
    end
  end

  assign strobe.valid          = out_valid_q;
  assign strobe.reg_select     = rs_q;
  assign strobe.nibble         = nib_q;
  assign strobe.lead_wait_us   = lead_q;
  assign strobe.settle_wait_us = settle_q;
  assign strobe.last           = last_q;

  assign status_o.drop     = (req_kind == REQ_CURSOR) && cursor_bad;
  assign status_o.last     = s_last;
  assign status_o.out_free = !out_valid_q || strobe.ready;

endmodule
